// File: hw/rtl/hqu_pkg.sv
// hqu_pkg: shared types and constants for the two-channel hit qualifier
// phase codes, register indexes, result bundle, register widths and reset values
// no dependencies
`default_nettype none
package hqu_pkg;

  localparam int TICK_COUNT_BITS_DEF = 16;
  localparam int LOCKOUT_BITS_DEF    = 20;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 20;
  localparam int SAMPLE_BITS    = 4;
  localparam int INTERVAL_BITS  = 16;
  localparam int LOCK_REG_BITS  = 20;

  // reset values of the configuration registers
  localparam logic [SAMPLE_BITS-1:0]   CONFIRM_SAMPLES_RST  = 4'd5;
  localparam logic [INTERVAL_BITS-1:0] CONFIRM_INTERVAL_RST = 16'd1000;
  localparam logic [SAMPLE_BITS-1:0]   CHECK_SAMPLES_RST    = 4'd2;
  localparam logic [INTERVAL_BITS-1:0] CHECK_INTERVAL_RST   = 16'd1000;
  localparam logic [INTERVAL_BITS-1:0] FALL_DELAY_RST       = 16'd1000;
  localparam logic [LOCK_REG_BITS-1:0] LOCKOUT_TICKS_RST    = 20'd50000;
  localparam logic [INTERVAL_BITS-1:0] PULSE_TICKS_RST      = 16'd10000;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CONFIRM_SAMPLES  = 3'd0,
    REG_CONFIRM_INTERVAL = 3'd1,
    REG_CHECK_SAMPLES    = 3'd2,
    REG_CHECK_INTERVAL   = 3'd3,
    REG_FALL_DELAY       = 3'd4,
    REG_LOCKOUT_TICKS    = 3'd5,
    REG_PULSE_TICKS      = 3'd6
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_CONFIRM   = 3'd1,
    PH_WAIT_FALL = 3'd2,
    PH_CHECK     = 3'd3,
    PH_TAIL      = 3'd4,
    PH_PULSE     = 3'd5
  } phase_t;

  typedef struct packed {
    logic head_pulse;
    logic body_pulse;
    logic indicator;
    logic locked_out;
  } result_t;

endpackage
`default_nettype wire

// File: hw/rtl/hqu_cfg.sv
// hqu_cfg: configuration registers, kept as counter load values
// interval and pulse lengths forced to >= 1 (fall delay not), saturated to counter widths
// depends on hqu_pkg
`default_nettype none
module hqu_cfg #(
  parameter int TICK_COUNT_BITS = hqu_pkg::TICK_COUNT_BITS_DEF,
  parameter int LOCKOUT_BITS    = hqu_pkg::LOCKOUT_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [hqu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [hqu_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  output logic      [hqu_pkg::SAMPLE_BITS-1:0]    confirm_samples,
  output logic      [TICK_COUNT_BITS-1:0]         confirm_load,
  output logic      [hqu_pkg::SAMPLE_BITS-1:0]    check_samples,
  output logic      [TICK_COUNT_BITS-1:0]         check_load,
  output logic      [TICK_COUNT_BITS-1:0]         fall_load,
  output logic      [LOCKOUT_BITS-1:0]            lockout_load,
  output logic      [TICK_COUNT_BITS-1:0]         pulse_load
);

  localparam logic [47:0] TickMax = (48'd1 << TICK_COUNT_BITS) - 48'd1;
  localparam logic [47:0] LockMax = (48'd1 << LOCKOUT_BITS) - 48'd1;

  function automatic logic [TICK_COUNT_BITS-1:0] tick_sat(
    input logic [hqu_pkg::INTERVAL_BITS-1:0] v,
    input logic                              at_least_one
  );
    logic [hqu_pkg::INTERVAL_BITS-1:0] m;
    m = (at_least_one && v == '0) ? hqu_pkg::INTERVAL_BITS'(1) : v;
    return (48'(m) > TickMax) ? TICK_COUNT_BITS'(TickMax) : TICK_COUNT_BITS'(m);
  endfunction

  function automatic logic [LOCKOUT_BITS-1:0] lock_sat(
    input logic [hqu_pkg::LOCK_REG_BITS-1:0] v
  );
    return (48'(v) > LockMax) ? LOCKOUT_BITS'(LockMax) : LOCKOUT_BITS'(v);
  endfunction

  logic [hqu_pkg::INTERVAL_BITS-1:0] wdata16;
  assign wdata16 = cfg_wdata[hqu_pkg::INTERVAL_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      confirm_samples <= hqu_pkg::CONFIRM_SAMPLES_RST;
      confirm_load    <= tick_sat(hqu_pkg::CONFIRM_INTERVAL_RST, 1'b1);
      check_samples   <= hqu_pkg::CHECK_SAMPLES_RST;
      check_load      <= tick_sat(hqu_pkg::CHECK_INTERVAL_RST, 1'b1);
      fall_load       <= tick_sat(hqu_pkg::FALL_DELAY_RST, 1'b0);
      lockout_load    <= lock_sat(hqu_pkg::LOCKOUT_TICKS_RST);
      pulse_load      <= tick_sat(hqu_pkg::PULSE_TICKS_RST, 1'b1);
    end else if (cfg_we) begin
      unique case (hqu_pkg::reg_index_t'(cfg_index))
        hqu_pkg::REG_CONFIRM_SAMPLES:
          confirm_samples <= cfg_wdata[hqu_pkg::SAMPLE_BITS-1:0];
        hqu_pkg::REG_CONFIRM_INTERVAL: confirm_load <= tick_sat(wdata16, 1'b1);
        hqu_pkg::REG_CHECK_SAMPLES:
          check_samples <= cfg_wdata[hqu_pkg::SAMPLE_BITS-1:0];
        hqu_pkg::REG_CHECK_INTERVAL:   check_load   <= tick_sat(wdata16, 1'b1);
        hqu_pkg::REG_FALL_DELAY:       fall_load    <= tick_sat(wdata16, 1'b0);
        hqu_pkg::REG_LOCKOUT_TICKS:
          lockout_load <= lock_sat(cfg_wdata[hqu_pkg::LOCK_REG_BITS-1:0]);
        hqu_pkg::REG_PULSE_TICKS:      pulse_load   <= tick_sat(wdata16, 1'b1);
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/hqu_step.sv
// hqu_step: per-tick qualifier state and next-state logic
// updates phase, counters and lockout on every accepted tick and forms its result
// depends on hqu_pkg
`default_nettype none
module hqu_step #(
  parameter int TICK_COUNT_BITS = hqu_pkg::TICK_COUNT_BITS_DEF,
  parameter int LOCKOUT_BITS    = hqu_pkg::LOCKOUT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            tick,
  input  wire logic                            primary_level,
  input  wire logic                            secondary_level,
  input  wire logic [hqu_pkg::SAMPLE_BITS-1:0] confirm_samples,
  input  wire logic [TICK_COUNT_BITS-1:0]      confirm_load,
  input  wire logic [hqu_pkg::SAMPLE_BITS-1:0] check_samples,
  input  wire logic [TICK_COUNT_BITS-1:0]      check_load,
  input  wire logic [TICK_COUNT_BITS-1:0]      fall_load,
  input  wire logic [LOCKOUT_BITS-1:0]         lockout_load,
  input  wire logic [TICK_COUNT_BITS-1:0]      pulse_load,
  output hqu_pkg::result_t                     result
);

  hqu_pkg::phase_t                 phase, phase_next;
  logic                            previous_primary, previous_primary_next;
  logic [hqu_pkg::SAMPLE_BITS-1:0] sample_count, sample_count_next;
  logic [TICK_COUNT_BITS-1:0]      interval_count, interval_count_next;
  logic [LOCKOUT_BITS-1:0]         lockout_count, lockout_count_next;
  logic                            head_flag, head_flag_next;

  logic [LOCKOUT_BITS-1:0]         lock_dec;
  logic [TICK_COUNT_BITS-1:0]      ic_dec;
  logic [hqu_pkg::SAMPLE_BITS-1:0] sample_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= hqu_pkg::PH_IDLE;
      previous_primary <= 1'b0;
      sample_count     <= '0;
      interval_count   <= '0;
      lockout_count    <= '0;
      head_flag        <= 1'b0;
    end else if (tick) begin
      phase            <= phase_next;
      previous_primary <= previous_primary_next;
      sample_count     <= sample_count_next;
      interval_count   <= interval_count_next;
      lockout_count    <= lockout_count_next;
      head_flag        <= head_flag_next;
    end
  end

  assign lock_dec   = (lockout_count != '0) ? lockout_count - LOCKOUT_BITS'(1) : lockout_count;
  assign ic_dec     = (interval_count != '0) ? interval_count - TICK_COUNT_BITS'(1)
                                             : interval_count;
  assign sample_inc = sample_count + hqu_pkg::SAMPLE_BITS'(1);

  always_comb begin
    phase_next            = phase;
    previous_primary_next = previous_primary;
    sample_count_next     = sample_count;
    interval_count_next   = interval_count;
    lockout_count_next    = lock_dec;
    head_flag_next        = head_flag;

    unique case (phase)
      hqu_pkg::PH_IDLE: begin
        // frozen while the lockout runs
        if (lock_dec == '0) begin
          if (!previous_primary && primary_level) begin
            if (confirm_samples == '0) begin
              phase_next = hqu_pkg::PH_WAIT_FALL;
            end else begin
              sample_count_next   = hqu_pkg::SAMPLE_BITS'(1);
              interval_count_next = confirm_load;
              phase_next          = hqu_pkg::PH_CONFIRM;
            end
          end
          previous_primary_next = primary_level;
        end
      end
      hqu_pkg::PH_CONFIRM: begin
        interval_count_next = ic_dec;
        if (ic_dec == '0) begin
          if (sample_count >= confirm_samples) begin
            phase_next = hqu_pkg::PH_WAIT_FALL;
          end else if (!primary_level) begin
            phase_next = hqu_pkg::PH_IDLE;
          end else begin
            sample_count_next   = sample_inc;
            interval_count_next = confirm_load;
          end
        end
      end
      hqu_pkg::PH_WAIT_FALL: begin
        if (!primary_level) begin
          phase_next          = hqu_pkg::PH_CHECK;
          sample_count_next   = '0;
          interval_count_next = fall_load;
        end
      end
      hqu_pkg::PH_CHECK: begin
        interval_count_next = ic_dec;
        if (ic_dec == '0) begin
          // lockout starts with the first secondary sample
          if (sample_count == '0) begin
            lockout_count_next = lockout_load;
          end
          if (check_samples == '0) begin
            head_flag_next      = 1'b1;
            phase_next          = hqu_pkg::PH_PULSE;
            interval_count_next = pulse_load;
          end else if (!secondary_level) begin
            head_flag_next      = 1'b0;
            phase_next          = hqu_pkg::PH_TAIL;
            interval_count_next = check_load;
          end else begin
            sample_count_next   = sample_inc;
            interval_count_next = check_load;
            if (sample_inc >= check_samples) begin
              head_flag_next = 1'b1;
              phase_next     = hqu_pkg::PH_TAIL;
            end
          end
        end
      end
      hqu_pkg::PH_TAIL: begin
        interval_count_next = ic_dec;
        if (ic_dec == '0) begin
          phase_next          = hqu_pkg::PH_PULSE;
          interval_count_next = pulse_load;
        end
      end
      hqu_pkg::PH_PULSE: begin
        interval_count_next = ic_dec;
        if (ic_dec == '0) begin
          phase_next = hqu_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_next = hqu_pkg::PH_IDLE;
      end
    endcase
  end

  always_comb begin
    result.head_pulse = (phase_next == hqu_pkg::PH_PULSE) && head_flag_next;
    result.body_pulse = (phase_next == hqu_pkg::PH_PULSE) && !head_flag_next;
    result.indicator  = (phase_next == hqu_pkg::PH_PULSE);
    result.locked_out = (phase_next == hqu_pkg::PH_IDLE) && (lockout_count_next != '0);
  end

endmodule
`default_nettype wire

// File: hw/rtl/hqu_out_buf.sv
// hqu_out_buf: two-entry result buffer between the tick logic and the output channel
// keeps input acceptance going while a result waits to be taken
// depends on hqu_pkg
`default_nettype none
module hqu_out_buf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire hqu_pkg::result_t din,
  output logic                  has_room,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output hqu_pkg::result_t      dout
);

  hqu_pkg::result_t entry0, entry1;
  logic [1:0]       count;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign has_room  = (count != 2'd2);
  assign dout      = entry0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    // new result lands in the first free slot after this cycle's transfer
    if (push && (count == 2'd0 || (count == 2'd1 && pop))) begin
      entry0 <= din;
    end else if (pop) begin
      entry0 <= entry1;
    end
    if (push && count != 2'd0 && !(count == 2'd1 && pop)) begin
      entry1 <= din;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/two_channel_hit_qualifier_unit.sv
// two_channel_hit_qualifier_unit: top level of the two-channel hit qualifier
// instantiates hqu_cfg, hqu_step and hqu_out_buf; depends on hqu_pkg
//
//   channel   signals                                  direction
//   in        in_valid/in_ready, primary/secondary     sink, one tick per transfer
//   out       out_valid/out_ready, pulses, lockout     source, one result per tick
//   cfg       cfg_we, cfg_index, cfg_wdata             write only, no handshake
//
// one tick is taken per cycle while in_ready is high; its state update is done in the
// cycle of the transfer; its result is pushed into the buffer and reaches the output
// once earlier results are taken; the two-entry buffer keeps ticks flowing while
// a result waits on out_ready; in_ready drops only with both entries held
// rst is synchronous and returns configuration and state to their defaults
`default_nettype none
module two_channel_hit_qualifier_unit #(
  parameter int TICK_COUNT_BITS = hqu_pkg::TICK_COUNT_BITS_DEF,
  parameter int LOCKOUT_BITS    = hqu_pkg::LOCKOUT_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               primary_level,
  input  wire logic                               secondary_level,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    head_pulse,
  output logic                                    body_pulse,
  output logic                                    indicator,
  output logic                                    locked_out,
  input  wire logic                               cfg_we,
  input  wire logic [hqu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [hqu_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  logic [hqu_pkg::SAMPLE_BITS-1:0] confirm_samples;
  logic [TICK_COUNT_BITS-1:0]      confirm_load;
  logic [hqu_pkg::SAMPLE_BITS-1:0] check_samples;
  logic [TICK_COUNT_BITS-1:0]      check_load;
  logic [TICK_COUNT_BITS-1:0]      fall_load;
  logic [LOCKOUT_BITS-1:0]         lockout_load;
  logic [TICK_COUNT_BITS-1:0]      pulse_load;

  logic             tick;
  hqu_pkg::result_t step_result;
  hqu_pkg::result_t out_result;

  assign tick = in_valid && in_ready;

  hqu_cfg #(
    .TICK_COUNT_BITS(TICK_COUNT_BITS),
    .LOCKOUT_BITS   (LOCKOUT_BITS)
  ) u_cfg (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .confirm_samples(confirm_samples),
    .confirm_load   (confirm_load),
    .check_samples  (check_samples),
    .check_load     (check_load),
    .fall_load      (fall_load),
    .lockout_load   (lockout_load),
    .pulse_load     (pulse_load)
  );

  hqu_step #(
    .TICK_COUNT_BITS(TICK_COUNT_BITS),
    .LOCKOUT_BITS   (LOCKOUT_BITS)
  ) u_step (
    .clk            (clk),
    .rst            (rst),
    .tick           (tick),
    .primary_level  (primary_level),
    .secondary_level(secondary_level),
    .confirm_samples(confirm_samples),
    .confirm_load   (confirm_load),
    .check_samples  (check_samples),
    .check_load     (check_load),
    .fall_load      (fall_load),
    .lockout_load   (lockout_load),
    .pulse_load     (pulse_load),
    .result         (step_result)
  );

  hqu_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (tick),
    .din      (step_result),
    .has_room (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .dout     (out_result)
  );

  assign head_pulse = out_result.head_pulse;
  assign body_pulse = out_result.body_pulse;
  assign indicator  = out_result.indicator;
  assign locked_out = out_result.locked_out;

endmodule
`default_nettype wire

// File: dv/two_channel_hit_qualifier_unit_tb.sv
`timescale 1ns / 1ps
// two_channel_hit_qualifier_unit_tb: self-checking bench for the two-channel hit qualifier
// feeds sensor ticks over valid/ready, predicts each tick's result and checks the output
// depends on hqu_pkg and two_channel_hit_qualifier_unit
module two_channel_hit_qualifier_unit_tb;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int PHASE_TICKS   = 75;
  localparam int RANDOM_PHASES = 5;
  localparam int REPORT_LIMIT  = 200;
  localparam logic [hqu_pkg::CFG_INDEX_BITS-1:0] SPARE_REG_INDEX = 3'd7;

  typedef struct packed {
    logic primary;
    logic secondary;
  } tick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic primary_level = 1'b0;
  logic secondary_level = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic head_pulse;
  logic body_pulse;
  logic indicator;
  logic locked_out;
  logic cfg_we = 1'b0;
  logic [hqu_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [hqu_pkg::CFG_DATA_BITS-1:0]  cfg_wdata = '0;

  // register copy
  logic [hqu_pkg::SAMPLE_BITS-1:0]   confirm_need;
  logic [hqu_pkg::SAMPLE_BITS-1:0]   check_need;
  logic [hqu_pkg::INTERVAL_BITS-1:0] confirm_gap;
  logic [hqu_pkg::INTERVAL_BITS-1:0] check_gap;
  logic [hqu_pkg::INTERVAL_BITS-1:0] fall_wait;
  logic [hqu_pkg::INTERVAL_BITS-1:0] pulse_len;
  logic [hqu_pkg::LOCK_REG_BITS-1:0] lockout_len;

  // qualifier state copy
  hqu_pkg::phase_t                   hit_phase;
  logic                              last_primary;
  logic [hqu_pkg::SAMPLE_BITS-1:0]   samples_seen;
  logic [hqu_pkg::INTERVAL_BITS-1:0] ticks_left;
  logic [hqu_pkg::LOCK_REG_BITS-1:0] lockout_left;
  logic                              head_hit;

  tick_t            tick_feed[$];
  hqu_pkg::result_t predicted_outputs[$];
  tick_t            next_tick;
  hqu_pkg::result_t want;
  int      ticks_fed = 0;
  int      ticks_taken = 0;
  int      mismatches = 0;
  int      cycle_count = 0;
  int      feed_gap = 0;
  int      stall_left = 0;
  int      in_gap_pct = 0;
  int      out_stall_pct = 0;
  logic    in_took = 1'b0;

  two_channel_hit_qualifier_unit dut (.*);

  always #5 clk = ~clk;

  function automatic logic [hqu_pkg::INTERVAL_BITS-1:0] at_least_one(
    input logic [hqu_pkg::INTERVAL_BITS-1:0] v
  );
    return (v == '0) ? hqu_pkg::INTERVAL_BITS'(1) : v;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30) : $urandom_range(1, 3);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 25;
      default: return 60;
    endcase
  endfunction

  function automatic int pick_value(input int zero_pct, input int hi, input int top_pct,
                                    input int top);
    int r;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return 0;
    if (r < zero_pct + top_pct) return top;
    return $urandom_range(1, hi);
  endfunction

  task automatic reset_model();
    confirm_need = hqu_pkg::CONFIRM_SAMPLES_RST;
    confirm_gap  = hqu_pkg::CONFIRM_INTERVAL_RST;
    check_need   = hqu_pkg::CHECK_SAMPLES_RST;
    check_gap    = hqu_pkg::CHECK_INTERVAL_RST;
    fall_wait    = hqu_pkg::FALL_DELAY_RST;
    lockout_len  = hqu_pkg::LOCKOUT_TICKS_RST;
    pulse_len    = hqu_pkg::PULSE_TICKS_RST;
    hit_phase    = hqu_pkg::PH_IDLE;
    last_primary = 1'b0;
    samples_seen = '0;
    ticks_left   = '0;
    lockout_left = '0;
    head_hit     = 1'b0;
  endtask

  task automatic start_pulse(input logic is_head);
    head_hit   = is_head;
    hit_phase  = hqu_pkg::PH_PULSE;
    ticks_left = at_least_one(pulse_len);
  endtask

  // one tick through the qualifier; queues the output it produces
  task automatic qualify_tick(input logic p, input logic s);
    hqu_pkg::result_t r;
    if (lockout_left != '0) lockout_left = lockout_left - 1'b1;
    case (hit_phase)
      hqu_pkg::PH_IDLE: begin
        // frozen while the lockout runs, edge history included
        if (lockout_left == '0) begin
          if (!last_primary && p) begin
            if (confirm_need == '0) begin
              hit_phase = hqu_pkg::PH_WAIT_FALL;
            end else begin
              samples_seen = hqu_pkg::SAMPLE_BITS'(1);
              ticks_left   = at_least_one(confirm_gap);
              hit_phase    = hqu_pkg::PH_CONFIRM;
            end
          end
          last_primary = p;
        end
      end
      hqu_pkg::PH_CONFIRM: begin
        if (ticks_left != '0) ticks_left = ticks_left - 1'b1;
        if (ticks_left == '0) begin
          if (samples_seen >= confirm_need) begin
            hit_phase = hqu_pkg::PH_WAIT_FALL;
          end else if (!p) begin
            hit_phase = hqu_pkg::PH_IDLE;
          end else begin
            samples_seen = samples_seen + 1'b1;
            ticks_left   = at_least_one(confirm_gap);
          end
        end
      end
      hqu_pkg::PH_WAIT_FALL: begin
        if (!p) begin
          hit_phase    = hqu_pkg::PH_CHECK;
          samples_seen = '0;
          ticks_left   = fall_wait;
        end
      end
      hqu_pkg::PH_CHECK: begin
        if (ticks_left != '0) ticks_left = ticks_left - 1'b1;
        if (ticks_left == '0) begin
          if (samples_seen == '0) lockout_left = lockout_len;
          if (check_need == '0) begin
            start_pulse(1'b1);
          end else if (!s) begin
            head_hit   = 1'b0;
            hit_phase  = hqu_pkg::PH_TAIL;
            ticks_left = at_least_one(check_gap);
          end else begin
            samples_seen = samples_seen + 1'b1;
            ticks_left   = at_least_one(check_gap);
            if (samples_seen >= check_need) begin
              head_hit  = 1'b1;
              hit_phase = hqu_pkg::PH_TAIL;
            end
          end
        end
      end
      hqu_pkg::PH_TAIL: begin
        if (ticks_left != '0) ticks_left = ticks_left - 1'b1;
        if (ticks_left == '0) start_pulse(head_hit);
      end
      hqu_pkg::PH_PULSE: begin
        if (ticks_left != '0) ticks_left = ticks_left - 1'b1;
        if (ticks_left == '0) hit_phase = hqu_pkg::PH_IDLE;
      end
      default: hit_phase = hqu_pkg::PH_IDLE;
    endcase
    r.head_pulse = (hit_phase == hqu_pkg::PH_PULSE) && head_hit;
    r.body_pulse = (hit_phase == hqu_pkg::PH_PULSE) && !head_hit;
    r.indicator  = (hit_phase == hqu_pkg::PH_PULSE);
    r.locked_out = (hit_phase == hqu_pkg::PH_IDLE) && (lockout_left != '0);
    predicted_outputs.push_back(r);
  endtask

  task automatic compare_field(input string field, input logic want_bit, input logic got_bit);
    if (got_bit !== want_bit) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s expected %b, actual %b", $time, field, want_bit, got_bit);
    end
  endtask

  // config writes, one per cycle; the caller lowers cfg_we afterwards
  task automatic write_reg(input logic [hqu_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [hqu_pkg::CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      hqu_pkg::REG_CONFIRM_SAMPLES:  confirm_need = data[hqu_pkg::SAMPLE_BITS-1:0];
      hqu_pkg::REG_CONFIRM_INTERVAL: confirm_gap  = data[hqu_pkg::INTERVAL_BITS-1:0];
      hqu_pkg::REG_CHECK_SAMPLES:    check_need   = data[hqu_pkg::SAMPLE_BITS-1:0];
      hqu_pkg::REG_CHECK_INTERVAL:   check_gap    = data[hqu_pkg::INTERVAL_BITS-1:0];
      hqu_pkg::REG_FALL_DELAY:       fall_wait    = data[hqu_pkg::INTERVAL_BITS-1:0];
      hqu_pkg::REG_LOCKOUT_TICKS:    lockout_len  = data[hqu_pkg::LOCK_REG_BITS-1:0];
      hqu_pkg::REG_PULSE_TICKS:      pulse_len    = data[hqu_pkg::INTERVAL_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic write_narrow(input hqu_pkg::reg_index_t idx, input int value, input int width);
    logic [hqu_pkg::CFG_DATA_BITS-1:0] raw;
    // junk above the register width must be dropped
    raw = hqu_pkg::CFG_DATA_BITS'($urandom);
    for (int b = 0; b < width; b++) raw[b] = value[b];
    write_reg(idx, raw);
  endtask

  task automatic load_settings(input int cs, input int ci, input int ks, input int ki,
                               input int fd, input int lk, input int pt);
    if ($urandom_range(0, 3) == 0)
      write_reg(SPARE_REG_INDEX, hqu_pkg::CFG_DATA_BITS'($urandom));
    write_narrow(hqu_pkg::REG_CONFIRM_SAMPLES, cs, hqu_pkg::SAMPLE_BITS);
    write_narrow(hqu_pkg::REG_CONFIRM_INTERVAL, ci, hqu_pkg::INTERVAL_BITS);
    write_narrow(hqu_pkg::REG_CHECK_SAMPLES, ks, hqu_pkg::SAMPLE_BITS);
    write_narrow(hqu_pkg::REG_CHECK_INTERVAL, ki, hqu_pkg::INTERVAL_BITS);
    write_narrow(hqu_pkg::REG_FALL_DELAY, fd, hqu_pkg::INTERVAL_BITS);
    write_narrow(hqu_pkg::REG_LOCKOUT_TICKS, lk, hqu_pkg::LOCK_REG_BITS);
    write_narrow(hqu_pkg::REG_PULSE_TICKS, pt, hqu_pkg::INTERVAL_BITS);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_tick(input logic p, input logic s);
    tick_feed.push_back({p, s});
    ticks_fed++;
  endtask

  task automatic push_pattern(input logic [15:0] p_bits, input logic [15:0] s_bits,
                              input int n);
    for (int i = n - 1; i >= 0; i--) push_tick(p_bits[i], s_bits[i]);
  endtask

  task automatic push_noise(input int n);
    repeat (n) push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // a rise, a high stretch long enough to confirm (sometimes not), then the check window
  task automatic queue_hit();
    int need;
    int high_len;
    int low_len;
    int mode;
    logic s;
    repeat ($urandom_range(1, 3)) push_tick(1'b0, 1'($urandom_range(0, 1)));
    need = int'(confirm_need) * int'(at_least_one(confirm_gap)) + 1;
    if ($urandom_range(0, 4) == 0) high_len = $urandom_range(1, need);
    else high_len = need + $urandom_range(0, 3);
    repeat (high_len) push_tick(1'b1, 1'($urandom_range(0, 1)));
    low_len = int'(fall_wait) + (int'(check_need) + 1) * int'(at_least_one(check_gap))
              + int'(at_least_one(pulse_len)) + $urandom_range(0, 4);
    mode = $urandom_range(0, 2);
    repeat (low_len) begin
      case (mode)
        0: s = 1'b1;
        1: s = ($urandom_range(0, 9) != 0);
        default: s = 1'($urandom_range(0, 1));
      endcase
      // the odd primary glitch while the secondary is being looked at
      push_tick($urandom_range(0, 19) == 0, s);
    end
    if (lockout_len != '0 && $urandom_range(0, 1) == 0) push_noise(int'(lockout_len));
  endtask

  // primary held low long enough for any hit in flight to finish and the lockout to expire
  task automatic queue_settle();
    int n;
    n = int'(confirm_need) * int'(at_least_one(confirm_gap)) + int'(fall_wait)
        + (int'(check_need) + 1) * int'(at_least_one(check_gap))
        + int'(at_least_one(pulse_len)) + int'(lockout_len) + 4;
    repeat (n) push_tick(1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic queue_phase(input int budget);
    int first;
    first = ticks_fed;
    while (ticks_fed - first < budget) begin
      if ($urandom_range(0, 5) == 0) push_noise($urandom_range(1, 10));
      else queue_hit();
    end
    queue_settle();
  endtask

  task automatic drain();
    do @(negedge clk);
    while (ticks_taken != ticks_fed || predicted_outputs.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // tick driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (feed_gap > 0) begin
        in_valid <= 1'b0;
        feed_gap--;
      end else if (tick_feed.size() != 0) begin
        next_tick = tick_feed.pop_front();
        in_valid        <= 1'b1;
        primary_level   <= next_tick.primary;
        secondary_level <= next_tick.secondary;
        feed_gap = ($urandom_range(0, 99) < in_gap_pct) ? gap_len() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result-side backpressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < out_stall_pct) stall_left = gap_len();
    end
  end

  // predict on each tick transfer, check on each result transfer
  always @(posedge clk) begin
    in_took <= in_valid && in_ready && !rst;
    if (!rst) begin
      if (in_valid && in_ready) begin
        qualify_tick(primary_level, secondary_level);
        ticks_taken++;
      end
      if (out_valid && out_ready) begin
        if (predicted_outputs.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result with no tick pending, expected none, actual %b%b%b%b",
                     $time, head_pulse, body_pulse, indicator, locked_out);
        end else begin
          want = predicted_outputs.pop_front();
          compare_field("head_pulse", want.head_pulse, head_pulse);
          compare_field("body_pulse", want.body_pulse, body_pulse);
          compare_field("indicator", want.indicator, indicator);
          compare_field("locked_out", want.locked_out, locked_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("two_channel_hit_qualifier_unit_tb failed");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // a few quiet ticks under the reset settings
    in_gap_pct    = 20;
    out_stall_pct = 20;
    push_pattern(16'b000, 16'b101, 3);
    drain();

    // failed confirm, no re-arm without a low, head hit with lockout reaching idle
    load_settings(2, 0, 2, 0, 0, 5, 0);
    push_pattern(16'b0101_0111_1000_0010, 16'b0000_0111_1111_0001, 16);
    drain();

    // edge alone confirms, no secondary samples means head at once
    load_settings(0, 1, 0, 1, 0, 0, 0);
    push_pattern(16'b001000, 16'b000001, 6);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      in_gap_pct    = pick_pct();
      out_stall_pct = pick_pct();
      load_settings(pick_value(10, 4, 10, 15), pick_value(15, 3, 0, 0),
                    pick_value(10, 4, 10, 15), pick_value(15, 3, 0, 0),
                    pick_value(25, 6, 0, 0), pick_value(30, 40, 0, 0),
                    pick_value(15, 6, 0, 0));
      queue_phase(PHASE_TICKS);
      drain();
    end

    // most samples, shortest intervals
    in_gap_pct    = 0;
    out_stall_pct = 0;
    load_settings(15, 0, 15, 0, 0, 0, 0);
    queue_phase(50);
    drain();

    // longest lockout and pulse; the hit lands in a pulse that outlasts the run
    in_gap_pct    = pick_pct();
    out_stall_pct = pick_pct();
    load_settings(0, 65535, 0, 65535, 0, 1048575, 65535);
    push_pattern(16'b00100, 16'b00111, 5);
    push_noise(20);
    drain();

    write_narrow(hqu_pkg::REG_FALL_DELAY, 65535, hqu_pkg::INTERVAL_BITS);
    @(negedge clk);
    cfg_we <= 1'b0;
    push_noise(10);
    drain();

    if (mismatches == 0) begin
      $display("two_channel_hit_qualifier_unit_tb passed");
    end else begin
      $display("two_channel_hit_qualifier_unit_tb failed");
    end
    $finish;
  end

endmodule
